// ----- design/lkvc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and constants for the lru key-value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int KEY_BITS        = 32;
    localparam int VALUE_BITS      = 32;
    localparam int CAP_BITS        = 5;
    localparam int DEFAULT_ENTRIES = 16;

    localparam logic [CAP_BITS-1:0]   CAP_RESET  = CAP_BITS'(16);
    localparam logic [VALUE_BITS-1:0] MISS_VALUE = '1;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    typedef struct packed {
        op_t                           operation;
        logic signed [KEY_BITS-1:0]    lookup_key;
        logic signed [VALUE_BITS-1:0]  store_value;
    } req_t;

    typedef struct packed {
        logic                          hit;
        logic signed [VALUE_BITS-1:0]  read_value;
        logic                          evicted;
        logic signed [KEY_BITS-1:0]    evicted_key;
    } rsp_t;

    typedef struct packed {
        logic update;
        logic put_miss;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- design/lkvc_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_cell
// one recency slot: holds a key and value, compares against the lookup key
// and takes its left neighbor's entry when the row shifts
// ----------------------------------------------------------------------------
module lkvc_cell
    import lkvc_pkg::*;
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic                  occupied,
    input  logic [KEY_BITS-1:0]   lookup_key,
    input  logic [KEY_BITS-1:0]   left_key,
    input  logic [VALUE_BITS-1:0] left_value,
    input  logic                  tail_match_in,
    output logic                  tail_match_out,
    output logic                  match,
    output logic [KEY_BITS-1:0]   key,
    output logic [VALUE_BITS-1:0] value
);

    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic                  load;

    assign match          = occupied && (key_reg == lookup_key);
    assign tail_match_out = match | tail_match_in;

    // shift when a new entry enters, or when a hit sits here or further down
    assign load = ctrl.update && (ctrl.put_miss || tail_match_out);

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        if (load)
        begin
            key_next   = left_key;
            value_next = left_value;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key   = key_reg;
    assign value = value_reg;

endmodule
`default_nettype wire

// ----- design/lru_key_value_cache_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// request channel (req_valid/req_ready/req) carries a get or a put of one key;
// each request gives exactly one response on rsp_valid/rsp_ready/rsp.
// the response is registered: it shows in the cycle after the request transfer.
// one request per cycle is taken while the response side keeps up; the cycle
// is set by the parallel key compare across the cell row and the one-step
// shift of the row. entries are kept in recency order, most recent in cell 0.
// when the receiver stalls, the response register holds and req_ready falls
// until that response is taken; a new request is accepted in the same cycle
// the held response transfers.
// cfg_valid/cfg_ready/cfg_data writes the capacity (0 acts as 1, values above
// ENTRIES act as ENTRIES); the user must write it only while no request is in
// flight; not enforced. reset (rst_n low, asynchronous) empties the store, drops
// any pending response and sets the capacity to 16. no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  req_t                req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output rsp_t                rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CAP_BITS-1:0] cfg_data
);

    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam logic [31:0] ENTRIES_W = 32'(ENTRIES);

    logic [OCC_W-1:0]      occupancy_reg;
    logic [OCC_W-1:0]      occupancy_next;
    logic [CAP_BITS-1:0]   capacity_reg;
    logic [CAP_BITS-1:0]   capacity_next;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;

    logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
    logic [VALUE_BITS-1:0] cell_value [ENTRIES];
    logic [KEY_BITS-1:0]   left_key   [ENTRIES];
    logic [VALUE_BITS-1:0] left_value [ENTRIES];
    logic [ENTRIES-1:0]    cell_match;
    logic [ENTRIES-1:0]    cell_last;
    logic [ENTRIES:0]      tail_match;

    cell_ctrl_t            ctrl;
    logic                  req_fire;
    logic                  is_put;
    logic                  hit;
    logic                  evict;
    logic [31:0]           cap_ext;
    logic [31:0]           eff_cap;
    logic [VALUE_BITS-1:0] hit_value;
    logic [VALUE_BITS-1:0] head_value;
    logic [KEY_BITS-1:0]   last_key;

    assign req_fire  = req_valid && req_ready;
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign cfg_ready = 1'b1;
    assign is_put    = (req.operation == OP_PUT);
    assign hit       = tail_match[0];

    assign tail_match[ENTRIES] = 1'b0;

    // most recent slot takes the request key; value is the new one on put
    assign head_value  = is_put ? VALUE_BITS'(req.store_value) : hit_value;
    assign left_key[0]   = KEY_BITS'(req.lookup_key);
    assign left_value[0] = head_value;

    assign ctrl.update   = req_fire && (hit || is_put);
    assign ctrl.put_miss = is_put && !hit;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            if (gi > 0)
            begin : g_link
                assign left_key[gi]   = cell_key[gi-1];
                assign left_value[gi] = cell_value[gi-1];
            end

            assign cell_last[gi] = (occupancy_reg == OCC_W'(gi + 1));

            lkvc_cell u_cell (
                .clk            (clk),
                .ctrl           (ctrl),
                .occupied       (occupancy_reg > OCC_W'(gi)),
                .lookup_key     (KEY_BITS'(req.lookup_key)),
                .left_key       (left_key[gi]),
                .left_value     (left_value[gi]),
                .tail_match_in  (tail_match[gi+1]),
                .tail_match_out (tail_match[gi]),
                .match          (cell_match[gi]),
                .key            (cell_key[gi]),
                .value          (cell_value[gi])
            );
        end
    endgenerate

    always_comb
    begin
        hit_value = '0;
        last_key  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_value = hit_value | (cell_value[i] & {VALUE_BITS{cell_match[i]}});
            last_key  = last_key  | (cell_key[i]   & {KEY_BITS{cell_last[i]}});
        end
    end

    always_comb
    begin
        cap_ext = 32'(capacity_reg);
        if (cap_ext == 32'd0)
        begin
            eff_cap = 32'd1;
        end
        else if (cap_ext > ENTRIES_W)
        begin
            eff_cap = ENTRIES_W;
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign evict = is_put && !hit && (32'(occupancy_reg) >= eff_cap);

    always_comb
    begin
        occupancy_next = occupancy_reg;
        if (req_fire && is_put && !hit && !evict)
        begin
            occupancy_next = occupancy_reg + OCC_W'(1);
        end

        capacity_next = cfg_valid ? cfg_data : capacity_reg;

        rsp_valid_next = req_fire || (rsp_valid_reg && !rsp_ready);

        rsp_next = rsp_reg;
        if (req_fire)
        begin
            rsp_next.hit         = hit;
            rsp_next.evicted     = evict;
            rsp_next.evicted_key = evict ? $signed(last_key) : '0;
            if (is_put)
            begin
                rsp_next.read_value = '0;
            end
            else if (hit)
            begin
                rsp_next.read_value = $signed(hit_value);
            end
            else
            begin
                rsp_next.read_value = $signed(MISS_VALUE);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupancy_reg <= '0;
            capacity_reg  <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            occupancy_reg <= occupancy_next;
            capacity_reg  <= capacity_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

// ----- design/lkvc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_checker
// port-level checks on the lru key-value cache, bound to the top level
// ----------------------------------------------------------------------------
module lkvc_checker
    import lkvc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input rsp_t                rsp
);

    // a pending response stays until its transfer
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before transfer");

    // every request transfer shows a response in the next cycle
    a_req_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("no response after request transfer");

    // an eviction only comes from a put of a new key
    a_evict_put_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.evicted |-> !rsp.hit && (rsp.read_value == '0))
        else $error("eviction reported on a hit or a get");

    // no eviction, no evicted key
    a_evict_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.evicted |-> (rsp.evicted_key == '0))
        else $error("evicted key set without eviction");

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (.*);
`default_nettype wire

// ----- test/tb_lru_key_value_cache_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_unit
// self-checking bench for the lru key-value cache unit
// ----------------------------------------------------------------------------
// a shadow copy of the cache (keys, values, ages, occupancy, capacity) is
// updated on every request transfer and gives the response that must come
// back; responses are compared field by field in transfer order. directed
// gets and puts at the key and value extremes and the capacity corner cases
// come first, then random traffic over key pools sized around each capacity
// setting, including a capacity lowered below the occupancy, a long response
// stall and a stretch at full rate.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_unit;
    import lkvc_pkg::*;

    localparam int ENTRIES     = DEFAULT_ENTRIES;
    localparam int CYCLE_LIMIT = 200000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    req_t                req;
    logic                rsp_valid;
    logic                rsp_ready;
    rsp_t                rsp;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CAP_BITS-1:0] cfg_data;

    logic [KEY_BITS-1:0]   line_key [ENTRIES];
    logic [VALUE_BITS-1:0] line_val [ENTRIES];
    bit                    line_live [ENTRIES];
    int unsigned           line_age [ENTRIES];
    int unsigned           live_count;
    logic [CAP_BITS-1:0]   cap_reg;

    rsp_t                  pending[$];
    rsp_t                  want;
    logic [KEY_BITS-1:0]   key_pool [32];

    int  errors;
    int  cycle_count;
    int  n_req;
    int  n_hits;
    int  n_evicts;
    int  n_cfg;
    bit  no_idle;
    int  stall_request;
    int  stall_left;

    lru_key_value_cache_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // shadow cache
    function automatic void promote(int s);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (line_live[i] && i != s && line_age[i] < line_age[s])
                line_age[i]++;
        end
        line_age[s] = 0;
    endfunction

    function automatic void add_line(int s, req_t r);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (line_live[i] && i != s)
                line_age[i]++;
        end
        line_live[s] = 1'b1;
        line_key[s]  = r.lookup_key;
        line_val[s]  = r.store_value;
        line_age[s]  = 0;
    endfunction

    function automatic rsp_t cache_access(req_t r);
        rsp_t        res;
        int          found;
        int          slot;
        int          victim;
        int unsigned oldest;
        int unsigned eff_cap;
        res     = '0;
        found   = -1;
        slot    = -1;
        victim  = -1;
        oldest  = 0;
        eff_cap = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (found < 0 && line_live[i] && line_key[i] == r.lookup_key)
                found = i;
        end
        if (r.operation == OP_GET)
        begin
            if (found >= 0)
            begin
                res.hit        = 1'b1;
                res.read_value = line_val[found];
                promote(found);
            end
            else
            begin
                res.read_value = MISS_VALUE;
            end
        end
        else if (found >= 0)
        begin
            res.hit         = 1'b1;
            line_val[found] = r.store_value;
            promote(found);
        end
        else if (live_count >= eff_cap)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (line_live[i] && (victim < 0 || line_age[i] > oldest))
                begin
                    victim = i;
                    oldest = line_age[i];
                end
            end
            res.evicted       = 1'b1;
            res.evicted_key   = line_key[victim];
            line_live[victim] = 1'b0;
            add_line(victim, r);
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (slot < 0 && !line_live[i])
                    slot = i;
            end
            add_line(slot, r);
            live_count++;
        end
        return res;
    endfunction

    // transfer monitor: response check, capacity write, request prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (pending.size() == 0)
                begin
                    $error("response transfer with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = pending.pop_front();
                    if (rsp.hit !== want.hit)
                    begin
                        $error("hit: expected %0b, got %0b", want.hit, rsp.hit);
                        errors++;
                    end
                    if (rsp.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %h, got %h",
                               want.read_value, rsp.read_value);
                        errors++;
                    end
                    if (rsp.evicted !== want.evicted)
                    begin
                        $error("evicted: expected %0b, got %0b", want.evicted, rsp.evicted);
                        errors++;
                    end
                    if (rsp.evicted_key !== want.evicted_key)
                    begin
                        $error("evicted_key: expected %h, got %h",
                               want.evicted_key, rsp.evicted_key);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                cap_reg = cfg_data;
            if (req_valid && req_ready)
            begin
                want = cache_access(req);
                pending = {pending, want};
                n_req++;
                n_hits   += want.hit;
                n_evicts += want.evicted;
            end
        end
    end

    // response side
    always @(negedge clk)
    begin
        if (stall_request > 0)
        begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= no_idle || ($urandom_range(99) >= 6);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic req_t make_req(op_t op, logic [KEY_BITS-1:0] k,
                                      logic [VALUE_BITS-1:0] v);
        req_t r;
        r.operation   = op;
        r.lookup_key  = k;
        r.store_value = v;
        return r;
    endfunction

    task automatic send_request(input req_t item);
        @(negedge clk);
        if (!no_idle && $urandom_range(99) < 6)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_capacity(input int unsigned value);
        wait_idle();
        cfg_data  <= CAP_BITS'(value);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    task automatic run_random(input int count, input int pool_n, input int put_pct);
        logic [KEY_BITS-1:0] k;
        op_t                 op;
        for (int i = 0; i < 32; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 85)
                k = key_pool[$urandom_range(pool_n - 1)];
            else
                k = $urandom;
            op = ($urandom_range(99) < put_pct) ? OP_PUT : OP_GET;
            send_request(make_req(op, k, $urandom));
        end
    endtask

    // capacity one and zero from an empty store
    task automatic test_capacity_extremes();
        send_request(make_req(OP_GET, 32'h0000_0000, 32'h0000_0000));
        write_capacity(1);
        send_request(make_req(OP_PUT, 32'h0000_0011, 32'h1111_1111));
        send_request(make_req(OP_PUT, 32'h0000_0022, 32'h2222_2222));
        send_request(make_req(OP_GET, 32'h0000_0011, 32'hffff_ffff));
        send_request(make_req(OP_GET, 32'h0000_0022, 32'h0000_0000));
        write_capacity(0);
        send_request(make_req(OP_PUT, 32'h0000_0033, 32'h3333_3333));
        send_request(make_req(OP_GET, 32'h0000_0033, 32'h0000_0000));
    endtask

    // key and value extremes, hits, misses and overwrite
    task automatic test_basic_ops();
        write_capacity(31);
        send_request(make_req(OP_PUT, 32'h8000_0000, 32'h7fff_ffff));
        send_request(make_req(OP_PUT, 32'h7fff_ffff, 32'h8000_0000));
        send_request(make_req(OP_PUT, 32'hffff_ffff, 32'hffff_ffff));
        send_request(make_req(OP_PUT, 32'h0000_0000, 32'h0000_0000));
        send_request(make_req(OP_GET, 32'h8000_0000, 32'h0000_0000));
        send_request(make_req(OP_GET, 32'hffff_ffff, 32'h5555_5555));
        send_request(make_req(OP_GET, 32'h1234_5678, 32'haaaa_aaaa));
        send_request(make_req(OP_PUT, 32'h7fff_ffff, 32'h5a5a_5a5a));
        send_request(make_req(OP_GET, 32'h7fff_ffff, 32'h0000_0000));
        send_request(make_req(OP_GET, 32'h0000_0000, 32'hffff_ffff));
    endtask

    // capacities rising from a nearly empty store, then lowered below occupancy
    task automatic test_capacity_sweep();
        int unsigned caps [12];
        int unsigned eff;
        caps = '{2, 3, 5, 8, 12, 17, 16, 31, 4, 0, 1, 24};
        for (int p = 0; p < 13; p++)
        begin
            eff = (p < 12) ? caps[p] : $urandom_range(31);
            write_capacity(eff);
            eff = (eff == 0) ? 1 : ((eff > ENTRIES) ? ENTRIES : eff);
            run_random(140, (eff + 4 < 6) ? 6 : eff + 4, 50);
        end
    endtask

    task automatic test_receiver_stall();
        write_capacity(16);
        stall_request = 80;
        run_random(120, 20, 50);
        wait_idle();
    endtask

    task automatic test_full_rate();
        no_idle = 1'b1;
        run_random(200, 20, 40);
        wait_idle();
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        rsp_ready     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        errors        = 0;
        cycle_count   = 0;
        n_req         = 0;
        n_hits        = 0;
        n_evicts      = 0;
        n_cfg         = 0;
        no_idle       = 1'b0;
        stall_request = 0;
        stall_left    = 0;
        live_count    = 0;
        cap_reg       = CAP_RESET;
        for (int i = 0; i < ENTRIES; i++)
        begin
            line_key[i]  = '0;
            line_val[i]  = '0;
            line_live[i] = 1'b0;
            line_age[i]  = 0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_capacity_extremes();
        test_basic_ops();
        test_capacity_sweep();
        test_receiver_stall();
        test_full_rate();

        wait_idle();
        repeat (10) @(posedge clk);
        if (pending.size() != 0)
        begin
            $error("%0d responses never arrived", pending.size());
            errors++;
        end
        $display("covered %0d gets and puts: %0d hits, %0d evictions", n_req, n_hits, n_evicts);
        $display("over %0d capacity writes, incl. zero, saturation and shrink", n_cfg);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- lru_key_value_cache_unit.f -----
design/lkvc_pkg.sv
design/lkvc_cell.sv
design/lru_key_value_cache_unit.sv
design/lkvc_checker.sv
test/tb_lru_key_value_cache_unit.sv
